### rtl/core/kct_pkg.sv
package kct_pkg;

	// default table depth
	localparam int SLOTS_DEF = 128;

	// field widths fixed by the command and result formats
	localparam int KEY_W   = 32;
	localparam int COUNT_W = 32;
	localparam int SLOT_W  = 7;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_SEARCH = 2'd1,
		CMD_UPDATE = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_e;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_DUP  = 2'd2,
		ST_MISS = 2'd3
	} status_e;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_HOLD
	} state_e;

	// one command transfer
	typedef struct packed {
		logic        [1:0]         command;
		logic signed [KEY_W-1:0]   part_key;
		logic signed [COUNT_W-1:0] amount;
	} in_t;

	// one result transfer
	typedef struct packed {
		logic        [1:0]         status;
		logic        [SLOT_W-1:0]  slot;
		logic signed [COUNT_W-1:0] count_out;
	} out_t;

	// probe token walking down the cell row
	typedef struct packed {
		logic                      live;
		logic                      hit;
		logic        [SLOT_W-1:0]  slot;
		logic signed [COUNT_W-1:0] count;
	} tok_t;

	// command held steady for the whole walk
	typedef struct packed {
		logic        [1:0]         cmd;
		logic signed [KEY_W-1:0]   key;
		logic signed [COUNT_W-1:0] amount;
	} ctl_t;

endpackage

### rtl/core/kct_cell.sv
module kct_cell #(
	parameter int IDX    = 0,
	parameter int CNT_W  = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  kct_pkg::ctl_t      ctl,
	input  logic [CNT_W-1:0]   used,
	input  kct_pkg::tok_t      tok_in,
	output kct_pkg::tok_t      tok_out
);

	localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

	logic signed [kct_pkg::KEY_W-1:0]   key_q;
	logic signed [kct_pkg::COUNT_W-1:0] count_q;
	logic                               live_s1;
	logic                               hit_s1;
	logic        [kct_pkg::SLOT_W-1:0]  slot_s1;
	logic signed [kct_pkg::COUNT_W-1:0] count_s1;

	logic                               in_use;
	logic                               match;
	logic                               upd;
	logic                               ins;
	logic signed [kct_pkg::COUNT_W-1:0] sum;

	// compare and write decisions for this entry
	always_comb begin
		in_use = (IDX_C < used);
		match  = tok_in.live && !tok_in.hit && in_use && (key_q == ctl.key);
		upd    = match && (ctl.cmd == kct_pkg::CMD_UPDATE);
		// first free entry, reached with no earlier match: take the new key
		ins    = tok_in.live && !tok_in.hit && (ctl.cmd == kct_pkg::CMD_INSERT) &&
		         (IDX_C == used);
		sum    = count_q + ctl.amount;
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (ins) begin
			key_q   <= ctl.key;
			count_q <= ctl.amount;
		end else if (upd) begin
			count_q <= sum;
		end
	end

	// token hand-off to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_s1 <= 1'b0;
		end else begin
			live_s1 <= tok_in.live;
		end
	end

	always_ff @(posedge clk) begin
		hit_s1 <= tok_in.hit | match;
		if (match) begin
			slot_s1  <= kct_pkg::SLOT_W'(IDX);
			count_s1 <= upd ? sum : count_q;
		end else begin
			slot_s1  <= tok_in.slot;
			count_s1 <= tok_in.count;
		end
	end

	assign tok_out = '{live: live_s1, hit: hit_s1, slot: slot_s1, count: count_s1};

endmodule

### rtl/core/keyed_count_table.sv
// A new command waits on cmd_stall until the previous one has walked the row
// and its result is loaded; a probe token walks the row of SLOTS cells one
// cell per cycle, whatever the command.
// A new command is taken while the previous result still waits on rsp_stall.
// Reset clears the fill count and all control; entry contents are not cleared.
module keyed_count_table #(
	parameter int SLOTS = kct_pkg::SLOTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  kct_pkg::in_t  cmd_data,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output kct_pkg::out_t rsp_data
);

	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam logic [CNT_W-1:0] FULL_C = CNT_W'(SLOTS);

	kct_pkg::state_e  state_q;
	kct_pkg::state_e  state_nx;
	kct_pkg::in_t     cmd_q;
	kct_pkg::ctl_t    ctl;
	logic [CNT_W-1:0] used_q;
	logic             start_q;
	kct_pkg::out_t    res_q;
	kct_pkg::out_t    res_nx;
	logic             rsp_valid_q;
	kct_pkg::out_t    rsp_data_q;

	kct_pkg::tok_t    tok [SLOTS+1];
	logic [SLOTS-1:0] live_vec;
	logic [CNT_W+6:0] used_ext;

	logic             accept;
	logic             capture;
	logic             load;
	logic             ins_ok;

	// cell row
	assign ctl.cmd    = cmd_q.command;
	assign ctl.key    = cmd_q.part_key;
	assign ctl.amount = cmd_q.amount;

	assign tok[0].live  = start_q;
	assign tok[0].hit   = 1'b0;
	assign tok[0].slot  = '0;
	assign tok[0].count = '0;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		kct_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.used    (used_q),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1])
		);
		assign live_vec[i] = tok[i+1].live;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			kct_pkg::S_IDLE: begin
				if (cmd_valid) state_nx = kct_pkg::S_RUN;
			end
			kct_pkg::S_RUN: begin
				if (tok[SLOTS].live) state_nx = kct_pkg::S_HOLD;
			end
			kct_pkg::S_HOLD: begin
				if (!rsp_valid_q || !rsp_stall) state_nx = kct_pkg::S_IDLE;
			end
			default: state_nx = kct_pkg::S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		cmd_stall = 1'b1;
		capture   = 1'b0;
		load      = 1'b0;
		unique case (state_q)
			kct_pkg::S_IDLE: cmd_stall = 1'b0;
			kct_pkg::S_RUN:  capture   = tok[SLOTS].live;
			kct_pkg::S_HOLD: load      = !rsp_valid_q || !rsp_stall;
			default: cmd_stall = 1'b1;
		endcase
	end

	assign accept = cmd_valid && !cmd_stall;

	// result from the token that left the last cell
	always_comb begin
		used_ext         = {7'b0, used_q};
		res_nx.status    = kct_pkg::ST_MISS;
		res_nx.slot      = '0;
		res_nx.count_out = '0;
		ins_ok           = 1'b0;
		case (cmd_q.command)
			kct_pkg::CMD_INSERT: begin
				if (used_q == FULL_C) begin
					res_nx.status = kct_pkg::ST_FULL;
				end else if (tok[SLOTS].hit) begin
					res_nx.status = kct_pkg::ST_DUP;
				end else begin
					res_nx.status    = kct_pkg::ST_OK;
					res_nx.slot      = used_ext[6:0];
					res_nx.count_out = cmd_q.amount;
					ins_ok           = 1'b1;
				end
			end
			kct_pkg::CMD_SEARCH, kct_pkg::CMD_UPDATE: begin
				if (tok[SLOTS].hit) begin
					res_nx.status    = kct_pkg::ST_OK;
					res_nx.slot      = tok[SLOTS].slot;
					res_nx.count_out = tok[SLOTS].count;
				end
			end
			default: res_nx.status = kct_pkg::ST_MISS;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kct_pkg::S_IDLE;
			start_q     <= 1'b0;
			used_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			start_q <= accept;
			if (capture && ins_ok) used_q <= used_q + 1'b1;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) cmd_q <= cmd_data;
		if (capture) res_q <= res_nx;
		if (load) rsp_data_q <= res_q;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

	// checks
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= FULL_C)
		else $error("fill count beyond table depth");

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(live_vec))
		else $error("more than one probe token in the row");

	a_tail_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		tok[SLOTS].live |-> state_q == kct_pkg::S_RUN)
		else $error("probe token left the row outside a walk");

	a_used_step: assert property (@(posedge clk) disable iff (!arst_n)
		used_q != $past(used_q) |-> used_q == $past(used_q) + 1'b1)
		else $error("fill count moved by other than one");

endmodule
